FILE: design/lbp_pkg.sv
`default_nettype none

package lbp_pkg;

    // Line buffer depth and the widths that follow from it
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int EW_W      = COL_W + 1;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int OUT_COL_W  = 10;
    localparam int ROW_W      = 12;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [WID_W-1:0] WID_RESET = WID_W'(640);
    localparam logic [HGT_W-1:0] HGT_RESET = HGT_W'(480);

    // Code bit of each neighbour, clockwise from the top-left
    localparam int NB_TOP_LEFT  = 0;
    localparam int NB_TOP       = 1;
    localparam int NB_TOP_RIGHT = 2;
    localparam int NB_RIGHT     = 3;
    localparam int NB_BOT_RIGHT = 4;
    localparam int NB_BOTTOM    = 5;
    localparam int NB_BOT_LEFT  = 6;
    localparam int NB_LEFT      = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pix_req;

    typedef struct packed {
        logic [CODE_W-1:0]    pattern_code;
        logic [OUT_COL_W-1:0] center_col;
        logic [ROW_W-1:0]     center_row;
        logic                 frame_done;
    } t_code_res;

    // Request held between the counter stage and the window stage
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_stage;

    // Line buffer write for both rows
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] one;
        logic [PIX_W-1:0] two;
    } t_lb_wr;

    // Window stage status back to the counter stage
    typedef struct packed {
        logic adv;
        logic emit;
    } t_win_sts;

    // Clamp the programmed width to 3..MAX_WIDTH
    function automatic logic [EW_W-1:0] eff_width(input logic [WID_W-1:0] w);
        logic [EW_W-1:0] res;
        if (w < WID_W'(3)) begin
            res = EW_W'(3);
        end else if (32'(w) > 32'(MAX_WIDTH)) begin
            res = EW_W'(MAX_WIDTH);
        end else begin
            res = EW_W'(w);
        end
        return res;
    endfunction

    // Clamp the programmed height to at least 3
    function automatic logic [HGT_W-1:0] eff_height(input logic [HGT_W-1:0] h);
        logic [HGT_W-1:0] res;
        if (h < HGT_W'(3)) begin
            res = HGT_W'(3);
        end else begin
            res = h;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/lbp_pix_if.sv
`default_nettype none

interface lbp_pix_if;
    import lbp_pkg::*;

    logic     valid;
    logic     ready;
    t_pix_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/lbp_code_if.sv
`default_nettype none

interface lbp_code_if;
    import lbp_pkg::*;

    logic      valid;
    logic      ready;
    t_code_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/lbp_3x3_pixel_stream.sv
`default_nettype none

// 3x3 local binary pattern over a raster stream of 8-bit grey pixels. One pixel
// request is taken per clock unless an untaken code holds the stage, and the code
// of a full window goes through the line buffer read, then the compare into the
// output register. Codes come only for interior centres, with the centre's row and
// column; frame_done marks the last interior centre of the frame. Frame size is set
// through the configuration port (index 0 width, 3..1024; index 1 height, >= 3) and
// must only be changed while the block is idle. The two previous rows sit in two
// 1024 x 8 line buffers with one write and one registered read port each; they are
// not cleared, so the first two rows of a frame produce no codes and need no reset
// contents. frame_start restarts the counters at the top-left corner.
module lbp_3x3_pixel_stream (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    lbp_pix_if.sink                             i_pix,
    lbp_code_if.source                          o_code,
    input  wire logic                           i_cfg_we,
    input  wire logic [lbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lbp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lbp_pkg::*;

    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;

    logic [EW_W-1:0]  w_eff;
    logic [HGT_W-1:0] h_eff;
    t_stage           s1;
    t_win_sts         sts;
    t_lb_wr           wr;
    logic             acc;
    logic [COL_W-1:0] rd_addr;
    logic [PIX_W-1:0] one_q;
    logic [PIX_W-1:0] two_q;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_RESET;
            r_height <= HGT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
            endcase
        end
    end

    assign w_eff = eff_width(r_width);
    assign h_eff = eff_height(r_height);

    lbp_ctr u_ctr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_width   (w_eff),
        .i_height  (h_eff),
        .i_sts     (sts),
        .o_s1      (s1),
        .o_acc     (acc),
        .o_rd_addr (rd_addr)
    );

    // Row one up
    lbp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_one (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.one),
        .i_re    (acc),
        .i_raddr (rd_addr),
        .o_rdata (one_q)
    );

    // Row two up
    lbp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.two),
        .i_re    (acc),
        .i_raddr (rd_addr),
        .o_rdata (two_q)
    );

    lbp_win u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_acc     (acc),
        .i_acc_col (rd_addr),
        .i_one_q   (one_q),
        .i_two_q   (two_q),
        .i_width   (w_eff),
        .i_height  (h_eff),
        .o_wr      (wr),
        .o_sts     (sts),
        .o_code    (o_code)
    );

    // A held stage request keeps its position and pixel
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1.valid && !sts.adv |=> $stable(s1))
        else $error("stage request changed while held");

    // A result moves on only into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.adv && sts.emit |-> !o_code.valid || o_code.ready)
        else $error("result overwrote one not taken");

    // Every result belongs to an interior centre
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_code.valid |-> (o_code.data.center_col != '0) && (o_code.data.center_row != '0))
        else $error("result on a border position");

endmodule

`default_nettype wire

FILE: design/lbp_ram.sv
`default_nettype none

module lbp_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/lbp_ctr.sv
`default_nettype none

module lbp_ctr (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    lbp_pix_if.sink                         i_pix,
    input  wire logic [lbp_pkg::EW_W-1:0]   i_width,
    input  wire logic [lbp_pkg::HGT_W-1:0]  i_height,
    input  wire lbp_pkg::t_win_sts          i_sts,
    output lbp_pkg::t_stage                 o_s1,
    output logic                            o_acc,
    output logic      [lbp_pkg::COL_W-1:0]  o_rd_addr
);
    import lbp_pkg::*;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_stage           r_s1;

    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [EW_W-1:0]  col_inc;
    logic [ROW_W:0]   row_inc;
    logic             acc;

    // Take a request whenever the stage register is free or moving on
    assign i_pix.ready = !r_s1.valid || i_sts.adv;
    assign acc         = i_pix.valid && i_pix.ready;

    // Position of this pixel; a frame start forces the top-left corner
    always_comb begin
        cur_col = i_pix.data.frame_start ? '0 : r_col;
        cur_row = i_pix.data.frame_start ? '0 : r_row;
        col_inc = {1'b0, cur_col} + EW_W'(1);
        row_inc = {1'b0, cur_row} + (ROW_W + 1)'(1);
        n_col   = COL_W'(col_inc);
        n_row   = cur_row;
        if (col_inc >= i_width) begin
            n_col = '0;
            if (row_inc >= {1'b0, i_height}) begin
                n_row = '0;
            end else begin
                n_row = ROW_W'(row_inc);
            end
        end
    end

    // Advance the counters and load the stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1  <= '0;
        end else if (acc) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_s1.valid  <= 1'b1;
            r_s1.pixel  <= i_pix.data.pixel;
            r_s1.col    <= cur_col;
            r_s1.row    <= cur_row;
        end else if (i_sts.adv) begin
            r_s1.valid  <= 1'b0;
        end
    end

    assign o_s1      = r_s1;
    assign o_acc     = acc;
    assign o_rd_addr = cur_col;

endmodule

`default_nettype wire

FILE: design/lbp_win.sv
`default_nettype none

module lbp_win (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire lbp_pkg::t_stage            i_s1,
    input  wire logic                       i_acc,
    input  wire logic [lbp_pkg::COL_W-1:0]  i_acc_col,
    input  wire logic [lbp_pkg::PIX_W-1:0]  i_one_q,
    input  wire logic [lbp_pkg::PIX_W-1:0]  i_two_q,
    input  wire logic [lbp_pkg::EW_W-1:0]   i_width,
    input  wire logic [lbp_pkg::HGT_W-1:0]  i_height,
    output lbp_pkg::t_lb_wr                 o_wr,
    output lbp_pkg::t_win_sts               o_sts,
    lbp_code_if.source                      o_code
);
    import lbp_pkg::*;

    logic [PIX_W-1:0] r_win [6];
    logic             r_byp;
    logic [PIX_W-1:0] r_byp_one;
    logic [PIX_W-1:0] r_byp_two;
    logic             r_out_valid;
    t_code_res        r_out;

    logic [PIX_W-1:0]  mid;
    logic [PIX_W-1:0]  top;
    logic [PIX_W-1:0]  ctr;
    logic [CODE_W-1:0] code;
    logic              emit;
    logic              adv;
    logic              last;
    t_code_res         n_out;

    // Rows above: take the value just written when the read hit the same column
    assign mid = r_byp ? r_byp_one : i_one_q;
    assign top = r_byp ? r_byp_two : i_two_q;
    assign ctr = r_win[4];

    // Interior centres only; move on unless a result would overwrite one not taken
    assign emit = i_s1.valid && (i_s1.row >= ROW_W'(2)) && (i_s1.col >= COL_W'(2));
    assign adv  = i_s1.valid && (!emit || !r_out_valid || o_code.ready);

    // Compare the eight neighbours with the centre
    always_comb begin
        code               = '0;
        code[NB_TOP_LEFT]  = r_win[0] >= ctr;
        code[NB_TOP]       = r_win[3] >= ctr;
        code[NB_TOP_RIGHT] = top >= ctr;
        code[NB_RIGHT]     = mid >= ctr;
        code[NB_BOT_RIGHT] = i_s1.pixel >= ctr;
        code[NB_BOTTOM]    = r_win[5] >= ctr;
        code[NB_BOT_LEFT]  = r_win[2] >= ctr;
        code[NB_LEFT]      = r_win[1] >= ctr;
    end

    assign last = (i_s1.row == i_height - HGT_W'(1))
               && ({1'b0, i_s1.col} == i_width - EW_W'(1));

    always_comb begin
        n_out.pattern_code = code;
        n_out.center_col   = OUT_COL_W'(i_s1.col - COL_W'(1));
        n_out.center_row   = i_s1.row - ROW_W'(1);
        n_out.frame_done   = last;
    end

    // Shift the window one column and note a same-column hit for the next request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
            r_byp <= 1'b0;
        end else begin
            if (adv) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= i_s1.pixel;
            end
            if (i_acc) begin
                r_byp <= adv && (i_acc_col == i_s1.col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_byp_one <= i_s1.pixel;
            r_byp_two <= mid;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_code.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= n_out;
        end
    end

    assign o_code.valid = r_out_valid;
    assign o_code.data  = r_out;

    assign o_wr.en   = adv;
    assign o_wr.addr = i_s1.col;
    assign o_wr.one  = i_s1.pixel;
    assign o_wr.two  = mid;

    assign o_sts.adv  = adv;
    assign o_sts.emit = emit;

endmodule

`default_nettype wire
